@@ rtl/core/tkvc_pkg.sv @@
package tkvc_pkg;

  // Parameter defaults
  localparam int unsigned DEF_ENTRIES    = 16;
  localparam int unsigned DEF_VALUE_BITS = 32;
  localparam int unsigned DEF_KEY_BITS   = 32;

  // Fixed field widths of the streams
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned TIME_W   = 31;
  localparam int unsigned TTL_W    = 16;
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned IN_DATA_W  = 112;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned OUT_USER_W = 3;

  localparam logic [TTL_W-1:0]  DFLT_LIFE_RESET = 16'd300;
  localparam logic [TIME_W-1:0] TIME_MAX        = 31'h7FFF_FFFF;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD   = 2'd0,
    ACT_GET   = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_ABSENT  = 2'd1,
    ST_EXPIRED = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

endpackage

@@ rtl/core/ttl_key_value_cache.sv @@
// Key/value cache of ENTRIES slots, each with an expiry time. in_tuser carries the
// action (add, get, clear, no-op) and the default-lifetime flag; one result transaction
// follows every input transaction. A single key comparator walks the table one
// slot per cycle through the table's read port; the block takes no new
// transaction until the result of the current one is in the output stage. A
// result waiting on out_tready does not stop the next transaction being
// accepted, but that transaction's result then holds in the output stage,
// with in_tready low, until the waiting one is taken. The default lifetime
// register is written through cfg_wen/cfg_wdata; the user must write it only
// while the block is idle, as the block itself does not enforce it.
module ttl_key_value_cache
  import tkvc_pkg::*;
#(
  parameter int unsigned ENTRIES    = DEF_ENTRIES,
  parameter int unsigned VALUE_BITS = DEF_VALUE_BITS,
  parameter int unsigned KEY_BITS   = DEF_KEY_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [31:0] key, [63:32] value, [94:64] time_now, [110:95] ttl, [111] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] action, [2] default-lifetime select
  input  logic [IN_USER_W-1:0]  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [31:0] value_out
  output logic [OUT_DATA_W-1:0] out_tdata,
  // [0] hit, [2:1] status
  output logic [OUT_USER_W-1:0] out_tuser,
  input  logic                  cfg_wen,
  input  logic [TTL_W-1:0]      cfg_wdata
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_WRITE,
    S_OUT
  } state_t;

  state_t                  state_r;
  logic [TTL_W-1:0]        def_ttl_r;
  logic [ENTRIES-1:0]      valid_r;

  // latched transaction
  action_t                 action_r;
  logic [KEY_BITS-1:0]     key_r;
  logic [VALUE_BITS-1:0]   value_r;
  logic [TIME_W-1:0]       time_r;
  logic [TTL_W-1:0]        ttl_r;
  logic                    use_def_r;

  // scan
  logic [CNT_W-1:0]        cnt_r;
  logic                    cmp_v_r;
  logic [IDX_W-1:0]        cmp_idx_r;
  logic                    found_r;
  logic [IDX_W-1:0]        found_idx_r;
  logic [TIME_W-1:0]       found_exp_r;
  logic [VALUE_BITS-1:0]   found_val_r;
  logic                    free_r;
  logic [IDX_W-1:0]        free_idx_r;

  // write-back
  logic                    wr_en_r;
  logic [IDX_W-1:0]        wr_idx_r;
  logic [TIME_W-1:0]       exp_r;

  // result
  logic                    res_hit_r;
  status_t                 res_status_r;
  logic [VALUE_BITS-1:0]   res_val_r;
  logic                    out_tvalid_r;
  logic [OUT_DATA_W-1:0]   out_tdata_r;
  logic [OUT_USER_W-1:0]   out_tuser_r;

  // table memory
  logic [KEY_BITS-1:0]     key_mem   [ENTRIES];
  logic [VALUE_BITS-1:0]   val_mem   [ENTRIES];
  logic [TIME_W-1:0]       exp_mem   [ENTRIES];
  logic [KEY_BITS-1:0]     rd_key_r;
  logic [VALUE_BITS-1:0]   rd_val_r;
  logic [TIME_W-1:0]       rd_exp_r;

  logic                    in_acc;
  logic [KEY_BITS+KEY_W-1:0]   key_ext;
  logic [VALUE_BITS+VAL_W-1:0] val_ext;
  logic [VAL_W+VALUE_BITS-1:0] vout_ext;
  logic [IDX_W-1:0]        rd_addr;
  logic                    scan_go;
  logic                    key_eq;
  logic [TTL_W-1:0]        life;
  logic [TIME_W:0]         exp_sum;
  logic [TIME_W-1:0]       exp_sat;
  logic                    mem_we;
  logic                    add_ok;
  logic [IDX_W-1:0]        tgt_idx;
  logic                    dec_hit;
  status_t                 dec_status;
  logic                    out_load;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  assign key_ext  = {{KEY_BITS{1'b0}}, in_tdata[KEY_W-1:0]};
  assign val_ext  = {{VALUE_BITS{1'b0}}, in_tdata[KEY_W +: VAL_W]};
  assign vout_ext = {{VAL_W{1'b0}}, res_val_r};

  assign rd_addr  = cnt_r[IDX_W-1:0];
  assign scan_go  = (state_r == S_SCAN) && (cnt_r < CNT_END);
  // the shared comparator: one stored key against the request per cycle
  assign key_eq   = valid_r[cmp_idx_r] && (rd_key_r == key_r);

  assign life     = use_def_r ? def_ttl_r : ttl_r;
  assign exp_sum  = {1'b0, time_r} + {{(TIME_W + 1 - TTL_W){1'b0}}, life};
  assign exp_sat  = exp_sum[TIME_W] ? TIME_MAX : exp_sum[TIME_W-1:0];

  assign mem_we   = (state_r == S_WRITE) && wr_en_r;

  assign add_ok   = (action_r == ACT_ADD) && (found_r || free_r);
  assign tgt_idx  = found_r ? found_idx_r : free_idx_r;
  // load the output register only once the previous result has gone
  assign out_load = (state_r == S_OUT) && (!out_tvalid_r || out_tready);

  always_comb begin
    dec_hit    = 1'b0;
    dec_status = ST_OK;
    unique case (action_r)
      ACT_ADD: begin
        if (!found_r && !free_r) begin
          dec_status = ST_FULL;
        end
      end
      ACT_GET: begin
        if (!found_r) begin
          dec_status = ST_ABSENT;
        end else if (found_exp_r < time_r) begin
          dec_status = ST_EXPIRED;
        end else begin
          dec_hit = 1'b1;
        end
      end
      ACT_CLEAR: begin
        if (!found_r) begin
          dec_status = ST_ABSENT;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[wr_idx_r] <= key_r;
      val_mem[wr_idx_r] <= value_r;
      exp_mem[wr_idx_r] <= exp_r;
    end
    rd_key_r <= key_mem[rd_addr];
    rd_val_r <= val_mem[rd_addr];
    rd_exp_r <= exp_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      def_ttl_r    <= DFLT_LIFE_RESET;
      valid_r      <= '0;
      cnt_r        <= '0;
      cmp_v_r      <= 1'b0;
      found_r      <= 1'b0;
      free_r       <= 1'b0;
      wr_en_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_wen) begin
        def_ttl_r <= cfg_wdata;
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      // compare stage works on the read address of the previous cycle
      cmp_v_r   <= scan_go;
      cmp_idx_r <= rd_addr;
      if (cmp_v_r) begin
        if (key_eq && !found_r) begin
          found_r     <= 1'b1;
          found_idx_r <= cmp_idx_r;
          found_exp_r <= rd_exp_r;
          found_val_r <= rd_val_r;
        end
        if (!valid_r[cmp_idx_r] && !free_r) begin
          free_r     <= 1'b1;
          free_idx_r <= cmp_idx_r;
        end
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            action_r  <= action_t'(in_tuser[ACTION_W-1:0]);
            use_def_r <= in_tuser[ACTION_W];
            key_r     <= key_ext[KEY_BITS-1:0];
            value_r   <= val_ext[VALUE_BITS-1:0];
            time_r    <= in_tdata[KEY_W + VAL_W +: TIME_W];
            ttl_r     <= in_tdata[KEY_W + VAL_W + TIME_W +: TTL_W];
            cnt_r     <= '0;
            found_r   <= 1'b0;
            free_r    <= 1'b0;
            state_r   <= S_SCAN;
          end
        end
        S_SCAN: begin
          // last compare lands in the cycle the counter reaches the end
          if (cnt_r == CNT_END) begin
            state_r <= S_DECIDE;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_DECIDE: begin
          res_hit_r    <= dec_hit;
          res_status_r <= dec_status;
          res_val_r    <= dec_hit ? found_val_r : '0;
          wr_en_r      <= add_ok;
          exp_r        <= exp_sat;
          wr_idx_r     <= tgt_idx;
          if (add_ok) begin
            valid_r[tgt_idx] <= 1'b1;
          end else if ((dec_status == ST_EXPIRED) ||
                       ((action_r == ACT_CLEAR) && found_r)) begin
            // drop the entry: expired on a get, or cleared
            valid_r[found_idx_r] <= 1'b0;
          end
          state_r <= S_WRITE;
        end
        S_WRITE: begin
          wr_en_r <= 1'b0;
          state_r <= S_OUT;
        end
        S_OUT: begin
          // hold until the output register is free
          if (out_load) begin
            out_tdata_r <= vout_ext[OUT_DATA_W-1:0];
            out_tuser_r <= {res_status_r, res_hit_r};
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("in_tready high in the cycle after an accepted transaction");

  a_hit_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tuser[2:1] == ST_OK)
    else $error("hit reported with a non-ok status");

  a_full_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WRITE && res_status_r == ST_FULL |-> &valid_r)
    else $error("table full reported while a slot is free");

  a_miss_no_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == '0)
    else $error("value_out non-zero without a hit");
`endif

endmodule
